// ===== hw/rtl/ctc_pkg.sv =====
// Shared constants, codes and control types of the COO to CSC converter.
package ctc_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_DIM     = 256;
    localparam int VALUE_WIDTH = 32;

    localparam int ENT_AW  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int DIM_AW  = $clog2(MAX_DIM);
    localparam int PTR_AW  = $clog2(MAX_DIM + 1);

    localparam int FUNC_W  = 2;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 11;
    localparam int STAT_W  = 2;
    localparam int CTOT_W  = 9;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 9;

    localparam logic [CFG_AW-1:0] CFG_COLUMN_TOTAL   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_VALUES_PRESENT = 2'd1;

    localparam logic [FUNC_W-1:0] FN_LOAD     = 2'd0;
    localparam logic [FUNC_W-1:0] FN_READ_PTR = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ_ENT = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_COL   = 2'd1,
        ST_FULL  = 2'd2,
        ST_INDEX = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LD_RD,
        S_LD_WR,
        S_PS_RD,
        S_PS_WR,
        S_SC_RD,
        S_SC_FILL,
        S_SC_WR,
        S_RP_RD,
        S_RP_CAP,
        S_ER_RD,
        S_ER_CAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic decode;
        logic ld_rd;
        logic ld_wr;
        logic ps_rd;
        logic ps_wr;
        logic sc_rd;
        logic sc_fill;
        logic sc_wr;
        logic rp_rd;
        logic rp_cap;
        logic er_rd;
        logic er_cap;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic load_go;
        logic ptr_go;
        logic ent_go;
        logic last;
        logic ps_end;
        logic sc_end;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/ctc_in_if.sv =====
// Request channel: valid/ready handshake with one request item.
interface ctc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ctc_pkg::FUNC_W-1:0]  func;
    logic [ctc_pkg::ROW_W-1:0]   entry_row;
    logic [ctc_pkg::COL_W-1:0]   entry_col;
    logic [ctc_pkg::VAL_W-1:0]   entry_value;
    logic                        entry_last;
    logic [ctc_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, func, entry_row, entry_col, entry_value, entry_last,
                    read_index, input ready);
    modport sink (input valid, func, entry_row, entry_col, entry_value, entry_last,
                  read_index, output ready);
endinterface

// ===== hw/rtl/ctc_out_if.sv =====
// Result channel: valid/ready handshake with one result item.
interface ctc_out_if;
    logic                        valid;
    logic                        ready;
    logic [ctc_pkg::STAT_W-1:0]  status;
    logic [ctc_pkg::IDX_W-1:0]   pointer_out;
    logic [ctc_pkg::ROW_W-1:0]   row_out;
    logic [ctc_pkg::VAL_W-1:0]   value_out;

    modport source (output valid, status, pointer_out, row_out, value_out, input ready);
    modport sink (input valid, status, pointer_out, row_out, value_out, output ready);
endinterface

// ===== hw/rtl/ctc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface ctc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ctc_pkg::CFG_AW-1:0]  index;
    logic [ctc_pkg::CFG_DW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ctc_ctrl.sv =====
// Sequencer of the converter: load, prefix sum, scatter and read phases.
module ctc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ctc_pkg::t_sts i_sts,
    output ctc_pkg::t_cmd o_cmd
);

    ctc_pkg::t_state r_state;
    ctc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ctc_pkg::S_DECODE;
            end
            ctc_pkg::S_DECODE: begin
                if (i_sts.load_go)     n_state = ctc_pkg::S_LD_RD;
                else if (i_sts.ptr_go) n_state = ctc_pkg::S_RP_RD;
                else if (i_sts.ent_go) n_state = ctc_pkg::S_ER_RD;
                else                   n_state = ctc_pkg::S_DONE;
            end
            ctc_pkg::S_LD_RD:   n_state = ctc_pkg::S_LD_WR;
            ctc_pkg::S_LD_WR:   n_state = i_sts.last ? ctc_pkg::S_PS_RD : ctc_pkg::S_DONE;
            ctc_pkg::S_PS_RD:   n_state = ctc_pkg::S_PS_WR;
            ctc_pkg::S_PS_WR:   n_state = i_sts.ps_end ? ctc_pkg::S_SC_RD : ctc_pkg::S_PS_RD;
            ctc_pkg::S_SC_RD:   n_state = ctc_pkg::S_SC_FILL;
            ctc_pkg::S_SC_FILL: n_state = ctc_pkg::S_SC_WR;
            ctc_pkg::S_SC_WR:   n_state = i_sts.sc_end ? ctc_pkg::S_DONE : ctc_pkg::S_SC_RD;
            ctc_pkg::S_RP_RD:   n_state = ctc_pkg::S_RP_CAP;
            ctc_pkg::S_RP_CAP:  n_state = ctc_pkg::S_DONE;
            ctc_pkg::S_ER_RD:   n_state = ctc_pkg::S_ER_CAP;
            ctc_pkg::S_ER_CAP:  n_state = ctc_pkg::S_DONE;
            ctc_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = ctc_pkg::S_IDLE;
            end
            default:            n_state = ctc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ctc_pkg::S_IDLE:    o_cmd.take    = 1'b1;
            ctc_pkg::S_DECODE:  o_cmd.decode  = 1'b1;
            ctc_pkg::S_LD_RD:   o_cmd.ld_rd   = 1'b1;
            ctc_pkg::S_LD_WR:   o_cmd.ld_wr   = 1'b1;
            ctc_pkg::S_PS_RD:   o_cmd.ps_rd   = 1'b1;
            ctc_pkg::S_PS_WR:   o_cmd.ps_wr   = 1'b1;
            ctc_pkg::S_SC_RD:   o_cmd.sc_rd   = 1'b1;
            ctc_pkg::S_SC_FILL: o_cmd.sc_fill = 1'b1;
            ctc_pkg::S_SC_WR:   o_cmd.sc_wr   = 1'b1;
            ctc_pkg::S_RP_RD:   o_cmd.rp_rd   = 1'b1;
            ctc_pkg::S_RP_CAP:  o_cmd.rp_cap  = 1'b1;
            ctc_pkg::S_ER_RD:   o_cmd.er_rd   = 1'b1;
            ctc_pkg::S_ER_CAP:  o_cmd.er_cap  = 1'b1;
            ctc_pkg::S_DONE:    o_cmd.push    = i_sts.out_free;
            default:            o_cmd         = '0;
        endcase
    end

endmodule

// ===== hw/rtl/ctc_dpath.sv =====
// Datapath: entry stores, pointer and fill memories, counters, result register.
module ctc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctc_pkg::t_cmd               i_cmd,
    output ctc_pkg::t_sts               o_sts,
    input  logic                        i_in_valid,
    input  logic [ctc_pkg::FUNC_W-1:0]  i_func,
    input  logic [ctc_pkg::ROW_W-1:0]   i_row,
    input  logic [ctc_pkg::COL_W-1:0]   i_col,
    input  logic [ctc_pkg::VAL_W-1:0]   i_val,
    input  logic                        i_last,
    input  logic [ctc_pkg::IDX_W-1:0]   i_idx,
    input  logic                        i_cfg_valid,
    input  logic [ctc_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [ctc_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ctc_pkg::STAT_W-1:0]  o_status,
    output logic [ctc_pkg::IDX_W-1:0]   o_pointer,
    output logic [ctc_pkg::ROW_W-1:0]   o_row,
    output logic [ctc_pkg::VAL_W-1:0]   o_value
);

    // Configuration and control state
    logic [ctc_pkg::CTOT_W-1:0]  r_col_total;
    logic                        r_val_pres;
    logic [ctc_pkg::CNT_W-1:0]   r_entry_count;
    logic                        r_complete;
    logic [ctc_pkg::MAX_DIM:0]   r_ptr_vld;
    logic                        r_out_valid;

    // Latched request
    logic [ctc_pkg::FUNC_W-1:0]      r_func;
    logic [ctc_pkg::ROW_W-1:0]       r_row;
    logic [ctc_pkg::COL_W-1:0]       r_col;
    logic [ctc_pkg::VALUE_WIDTH-1:0] r_val;
    logic                            r_last;
    logic [ctc_pkg::IDX_W-1:0]       r_idx;

    // Sweep counters
    logic [ctc_pkg::DIM_AW-1:0]  r_ps_k;
    logic [ctc_pkg::CNT_W-1:0]   r_sum;
    logic [ctc_pkg::CNT_W-1:0]   r_sc_idx;

    // Memories
    logic [ctc_pkg::ROW_W-1:0]       m_ld_row [ctc_pkg::MAX_ENTRIES];
    logic [ctc_pkg::DIM_AW-1:0]      m_ld_col [ctc_pkg::MAX_ENTRIES];
    logic [ctc_pkg::VALUE_WIDTH-1:0] m_ld_val [ctc_pkg::MAX_ENTRIES];
    logic [ctc_pkg::CNT_W-1:0]       m_ptr    [ctc_pkg::MAX_DIM+1];
    logic [ctc_pkg::CNT_W-1:0]       m_fill   [ctc_pkg::MAX_DIM];
    logic [ctc_pkg::ROW_W-1:0]       m_cv_row [ctc_pkg::MAX_ENTRIES];
    logic [ctc_pkg::VALUE_WIDTH-1:0] m_cv_val [ctc_pkg::MAX_ENTRIES];

    logic [ctc_pkg::ROW_W-1:0]       r_lr_q;
    logic [ctc_pkg::DIM_AW-1:0]      r_lc_q;
    logic [ctc_pkg::VALUE_WIDTH-1:0] r_lv_q;
    logic [ctc_pkg::CNT_W-1:0]       r_pm_q;
    logic                            r_pm_vq;
    logic [ctc_pkg::CNT_W-1:0]       r_fl_q;
    logic [ctc_pkg::ROW_W-1:0]       r_cr_q;
    logic [ctc_pkg::VALUE_WIDTH-1:0] r_cv_q;

    // Pending result and output register
    ctc_pkg::t_status               r_rs_status;
    logic [ctc_pkg::IDX_W-1:0]      r_rs_ptr;
    logic [ctc_pkg::ROW_W-1:0]      r_rs_row;
    logic [ctc_pkg::VAL_W-1:0]      r_rs_val;
    logic [ctc_pkg::STAT_W-1:0]     r_o_status;
    logic [ctc_pkg::IDX_W-1:0]      r_o_ptr;
    logic [ctc_pkg::ROW_W-1:0]      r_o_row;
    logic [ctc_pkg::VAL_W-1:0]      r_o_val;

    logic [ctc_pkg::CTOT_W-1:0]  w_act;
    logic [ctc_pkg::CNT_W-1:0]   w_cnt;
    ctc_pkg::t_status            w_dec_status;
    logic                        w_load_go;
    logic                        w_ptr_go;
    logic                        w_ent_go;
    logic [ctc_pkg::PTR_AW-1:0]  w_pa;
    logic [ctc_pkg::CNT_W-1:0]   w_pm_rd;
    logic [ctc_pkg::CNT_W-1:0]   w_pw;
    logic                        w_out_free;

    assign w_act = (r_col_total > ctc_pkg::CTOT_W'(ctc_pkg::MAX_DIM))
                 ? ctc_pkg::CTOT_W'(ctc_pkg::MAX_DIM) : r_col_total;
    assign w_cnt = r_complete ? '0 : r_entry_count;

    // Classify the latched request
    always_comb begin
        w_dec_status = ctc_pkg::ST_OK;
        w_load_go    = 1'b0;
        w_ptr_go     = 1'b0;
        w_ent_go     = 1'b0;
        unique case (r_func)
            ctc_pkg::FN_LOAD: begin
                if (ctc_pkg::CTOT_W'(r_col) >= w_act) begin
                    w_dec_status = ctc_pkg::ST_COL;
                end else if (w_cnt >= ctc_pkg::CNT_W'(ctc_pkg::MAX_ENTRIES)) begin
                    w_dec_status = ctc_pkg::ST_FULL;
                end else begin
                    w_load_go = 1'b1;
                end
            end
            ctc_pkg::FN_READ_PTR: begin
                if (r_idx > ctc_pkg::IDX_W'(w_act)) w_dec_status = ctc_pkg::ST_INDEX;
                else                                w_ptr_go     = 1'b1;
            end
            ctc_pkg::FN_READ_ENT: begin
                if (!r_complete || r_idx >= ctc_pkg::IDX_W'(r_entry_count)) begin
                    w_dec_status = ctc_pkg::ST_INDEX;
                end else begin
                    w_ent_go = 1'b1;
                end
            end
            default: w_dec_status = ctc_pkg::ST_INDEX;
        endcase
    end

    // Pointer memory address: load column slot, sweep slot or read index
    always_comb begin
        if (i_cmd.ld_rd || i_cmd.ld_wr) begin
            w_pa = ctc_pkg::PTR_AW'(r_col) + ctc_pkg::PTR_AW'(1);
        end else if (i_cmd.ps_rd || i_cmd.ps_wr) begin
            w_pa = ctc_pkg::PTR_AW'(r_ps_k) + ctc_pkg::PTR_AW'(1);
        end else begin
            w_pa = r_idx[ctc_pkg::PTR_AW-1:0];
        end
    end

    assign w_pm_rd    = r_pm_vq ? r_pm_q : '0;
    assign w_pw       = i_cmd.ps_wr ? (r_sum + w_pm_rd) : (w_pm_rd + ctc_pkg::CNT_W'(1));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_total   <= ctc_pkg::CTOT_W'(ctc_pkg::MAX_DIM);
            r_val_pres    <= 1'b1;
            r_entry_count <= '0;
            r_complete    <= 1'b0;
            r_ptr_vld     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ctc_pkg::CFG_COLUMN_TOTAL:   r_col_total <= i_cfg_data[ctc_pkg::CTOT_W-1:0];
                    ctc_pkg::CFG_VALUES_PRESENT: r_val_pres  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Start a new matrix on the first accepted load after completion
            if (i_cmd.decode && w_load_go && r_complete) begin
                r_ptr_vld     <= '0;
                r_entry_count <= '0;
                r_complete    <= 1'b0;
            end
            if (i_cmd.ld_wr) r_entry_count <= r_entry_count + ctc_pkg::CNT_W'(1);
            if (i_cmd.ld_wr || i_cmd.ps_wr) r_ptr_vld[w_pa] <= 1'b1;
            if (i_cmd.sc_wr && o_sts.sc_end) r_complete <= 1'b1;
            if (i_cmd.push)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Request latch, counters, pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_in_valid) begin
            r_func <= i_func;
            r_row  <= i_row;
            r_col  <= i_col;
            r_val  <= i_val[ctc_pkg::VALUE_WIDTH-1:0];
            r_last <= i_last;
            r_idx  <= i_idx;
        end
        if (i_cmd.decode) begin
            r_rs_status <= w_dec_status;
            r_rs_ptr    <= '0;
            r_rs_row    <= '0;
            r_rs_val    <= '0;
        end
        if (i_cmd.ld_wr) begin
            r_rs_ptr <= ctc_pkg::IDX_W'(r_entry_count + ctc_pkg::CNT_W'(1));
            r_ps_k   <= '0;
            r_sum    <= '0;
            r_sc_idx <= '0;
        end
        if (i_cmd.ps_wr) begin
            r_sum  <= w_pw;
            r_ps_k <= r_ps_k + ctc_pkg::DIM_AW'(1);
        end
        if (i_cmd.sc_wr) r_sc_idx <= r_sc_idx + ctc_pkg::CNT_W'(1);
        if (i_cmd.rp_cap) r_rs_ptr <= ctc_pkg::IDX_W'(w_pm_rd);
        if (i_cmd.er_cap) begin
            r_rs_row <= r_cr_q;
            r_rs_val <= r_val_pres ? ctc_pkg::VAL_W'(r_cv_q) : '0;
        end
        if (i_cmd.push) begin
            r_o_status <= r_rs_status;
            r_o_ptr    <= r_rs_ptr;
            r_o_row    <= r_rs_row;
            r_o_val    <= r_rs_val;
        end
    end

    // Loaded entry store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_rd) begin
            m_ld_row[r_entry_count[ctc_pkg::ENT_AW-1:0]] <= r_row;
            m_ld_col[r_entry_count[ctc_pkg::ENT_AW-1:0]] <= r_col[ctc_pkg::DIM_AW-1:0];
            m_ld_val[r_entry_count[ctc_pkg::ENT_AW-1:0]] <= r_val;
        end
        if (i_cmd.sc_rd) begin
            r_lr_q <= m_ld_row[r_sc_idx[ctc_pkg::ENT_AW-1:0]];
            r_lc_q <= m_ld_col[r_sc_idx[ctc_pkg::ENT_AW-1:0]];
            r_lv_q <= m_ld_val[r_sc_idx[ctc_pkg::ENT_AW-1:0]];
        end
    end

    // Column pointer memory; entries without a valid bit read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr || i_cmd.ps_wr) m_ptr[w_pa] <= w_pw;
        if (i_cmd.ld_rd || i_cmd.ps_rd || i_cmd.rp_rd) begin
            r_pm_q  <= m_ptr[w_pa];
            r_pm_vq <= r_ptr_vld[w_pa];
        end
    end

    // Column fill memory: seeded with start pointers, then bumped per scatter
    always_ff @(posedge i_clk) begin
        if (i_cmd.ps_rd) m_fill[r_ps_k] <= r_sum;
        if (i_cmd.sc_wr) m_fill[r_lc_q] <= r_fl_q + ctc_pkg::CNT_W'(1);
        if (i_cmd.sc_fill) r_fl_q <= m_fill[r_lc_q];
    end

    // Converted entry store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_wr) begin
            m_cv_row[r_fl_q[ctc_pkg::ENT_AW-1:0]] <= r_lr_q;
            m_cv_val[r_fl_q[ctc_pkg::ENT_AW-1:0]] <= r_lv_q;
        end
        if (i_cmd.er_rd) begin
            r_cr_q <= m_cv_row[r_idx[ctc_pkg::ENT_AW-1:0]];
            r_cv_q <= m_cv_val[r_idx[ctc_pkg::ENT_AW-1:0]];
        end
    end

    assign o_sts.load_go  = w_load_go;
    assign o_sts.ptr_go   = w_ptr_go;
    assign o_sts.ent_go   = w_ent_go;
    assign o_sts.last     = r_last;
    assign o_sts.ps_end   = (r_ps_k == ctc_pkg::DIM_AW'(ctc_pkg::MAX_DIM - 1));
    assign o_sts.sc_end   = ((r_sc_idx + ctc_pkg::CNT_W'(1)) == r_entry_count);
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_pointer   = r_o_ptr;
    assign o_row       = r_o_row;
    assign o_value     = r_o_val;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= ctc_pkg::CNT_W'(ctc_pkg::MAX_ENTRIES))
        else $error("entry count beyond capacity");

    a_complete_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_entry_count != '0))
        else $error("complete matrix with no entries");

    a_scatter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sc_wr |-> (r_sc_idx < r_entry_count))
        else $error("scatter past entry count");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> w_out_free)
        else $error("result pushed over a waiting result");

endmodule

// ===== hw/rtl/coo_to_csc_converter_top.sv =====
// Top level of the COO to CSC converter: sequencer plus datapath.
// The entry marked last adds a prefix sum over all 256 columns, each column read and then written,
// and a scatter of every held entry, which reads the entry, reads its column fill, then writes.
// Throughput: one item at a time; a finished result may wait while the next is accepted.
// Reset (i_rst_n, synchronous, active low) clears counts, pointer valid bits and flags and restores
// the configuration defaults at once; the entry stores are not cleared and need no clearing pass.
module coo_to_csc_converter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctc_in_if.sink    i_in,
    ctc_out_if.source o_out,
    ctc_cfg_if.sink   i_cfg
);

    ctc_pkg::t_cmd w_cmd;
    ctc_pkg::t_sts w_sts;

    // Requests are taken only while the sequencer sits idle
    assign i_in.ready  = w_cmd.take;
    // Registers are plain flops, so writes are always taken
    assign i_cfg.ready = 1'b1;

    ctc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ctc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_valid  (i_in.valid),
        .i_func      (i_in.func),
        .i_row       (i_in.entry_row),
        .i_col       (i_in.entry_col),
        .i_val       (i_in.entry_value),
        .i_last      (i_in.entry_last),
        .i_idx       (i_in.read_index),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_pointer   (o_out.pointer_out),
        .o_row       (o_out.row_out),
        .o_value     (o_out.value_out)
    );

endmodule
